[hdl/mftp_pkg.sv]
// Shared types, character codes and helper functions for the mixed fraction text parser.
`timescale 1ns / 1ps
package mftp_pkg;

  localparam int MAX_LENGTH_DEF    = 4095;
  localparam int FRACTION_BITS_DEF = 32;
  localparam int LEN_W             = 12;
  localparam int VALUE_W           = 64;
  localparam int DEC_W             = 5;
  localparam logic [DEC_W-1:0] DEC_MAX = 5'd19;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // One finished number, handed from the parser to the evaluator.
  typedef struct packed {
    logic [63:0]      mant;
    logic [DEC_W-1:0] dcnt;
    logic [31:0]      den1;
    logic [31:0]      num2;
    logic [31:0]      den2;
    logic             with_second;
    logic             sat;
    logic             sat2;
    logic [LEN_W-1:0] len;
  } job_t;

  // Returns {overflow, v*10+d} for a 64-bit accumulator.
  function automatic logic [64:0] mul10_add64(input logic [63:0] v, input logic [3:0] d);
    logic [67:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {64'b0, d};
    return {|t[67:64], t[63:0]};
  endfunction

  // Returns {overflow, v*10+d} for a 32-bit accumulator.
  function automatic logic [32:0] mul10_add32(input logic [31:0] v, input logic [3:0] d);
    logic [35:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {32'b0, d};
    return {|t[35:32], t[31:0]};
  endfunction

  function automatic logic [63:0] pow_ten(input logic [DEC_W-1:0] n);
    logic [63:0] p;
    case (n)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

[hdl/mixed_fraction_text_parser_unit.sv]
// Top level of the mixed fraction text parser: parser, job queue and evaluator.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------------------------
//   input   | in        | in_valid / in_ready  | ch, start_req
//   result  | out       | out_valid / out_ready| value, consumed_length, divide_by_zero, overflow
//
// Characters are taken at one per cycle while the job queue has room; a terminating
// character is accepted and becomes a job in the same cycle.
// Each number is evaluated by the restoring divider in the evaluator, which produces
// one quotient bit a cycle; a second term, when present, takes a second division.
// Reset is synchronous and active high; it empties the queue and the result register.
// The parser stalls only when the two-entry queue is full; the evaluator stalls only
// while its result register still holds a transaction that has not been taken.
`timescale 1ns / 1ps
module mixed_fraction_text_parser_unit #(
  parameter int MAX_LENGTH    = mftp_pkg::MAX_LENGTH_DEF,
  parameter int FRACTION_BITS = mftp_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 ch,
  input  logic                       start_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [63:0]                value,
  output logic [mftp_pkg::LEN_W-1:0] consumed_length,
  output logic                       divide_by_zero,
  output logic                       overflow
);
  mftp_pkg::job_t push_job, pop_job;
  logic           push, pop, q_full, q_avail;

  // Front end: classifies each character and tracks the parse.
  mftp_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
    .start_req(start_req), .q_full(q_full), .push(push), .job(push_job)
  );

  // The queue lets the parser run ahead while a division is in progress.
  mftp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .full(q_full),
    .pop(pop), .avail(q_avail), .pop_job(pop_job)
  );

  // Back end: fixed-point division, saturation and the result register.
  mftp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .q_avail(q_avail), .q_job(pop_job), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .value(value),
    .consumed_length(consumed_length), .divide_by_zero(divide_by_zero),
    .overflow(overflow)
  );
endmodule

[hdl/mftp_front.sv]
// Character parser: accepts one character a cycle while the job queue is not full and emits a finished number job.
`timescale 1ns / 1ps
module mftp_front #(
  parameter int MAX_LENGTH = mftp_pkg::MAX_LENGTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     ch,
  input  logic           start_req,
  input  logic           q_full,
  output logic           push,
  output mftp_pkg::job_t job
);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEAD, PH_INT, PH_DEC, PH_SL1, PH_DEN1, PH_MID, PH_NUM2, PH_SL2, PH_DEN2
  } phase_t;

  phase_t                       phase, phase_next, e_phase;
  logic [63:0]                  mant, mant_next, e_mant;
  logic [mftp_pkg::DEC_W-1:0]   dcnt, dcnt_next, e_dcnt;
  logic [31:0]                  den1, den1_next, e_den1;
  logic [31:0]                  num2, num2_next, e_num2;
  logic [31:0]                  den2, den2_next, e_den2;
  logic [CNT_W-1:0]             cnt, cnt_next, e_cnt;
  logic [CNT_W-1:0]             bpos, bpos_next, e_bpos;
  logic                         sat, sat_next, e_sat;
  logic                         sat2, sat2_next, e_sat2;

  logic             accept, active, dig, ws, count_c, fin, fin_sec;
  logic [CNT_W-1:0] fin_len;
  logic [3:0]       d;
  logic [64:0]      m10;
  logic [32:0]      a_den1, a_num2, a_den2;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign dig = (ch >= mftp_pkg::CH_ZERO) && (ch <= mftp_pkg::CH_NINE);
  assign ws  = (ch == mftp_pkg::CH_SPACE) ||
               ((ch >= mftp_pkg::CH_TAB) && (ch <= mftp_pkg::CH_CR));
  assign d   = dig ? ch[3:0] : 4'd0;

  always_comb begin
    if (start_req) begin
      e_phase = PH_LEAD; e_mant = '0; e_dcnt = '0; e_den1 = 32'd1; e_num2 = '0;
      e_den2 = '0; e_cnt = '0; e_bpos = '0; e_sat = 1'b0; e_sat2 = 1'b0;
    end else begin
      e_phase = phase; e_mant = mant; e_dcnt = dcnt; e_den1 = den1; e_num2 = num2;
      e_den2 = den2; e_cnt = cnt; e_bpos = bpos; e_sat = sat; e_sat2 = sat2;
    end
    active  = start_req || (phase != PH_IDLE);
    m10     = mftp_pkg::mul10_add64(e_mant, d);
    a_den1  = mftp_pkg::mul10_add32(e_den1, d);
    a_num2  = mftp_pkg::mul10_add32(e_num2, d);
    a_den2  = mftp_pkg::mul10_add32(e_den2, d);
    phase_next = e_phase; mant_next = e_mant; dcnt_next = e_dcnt; den1_next = e_den1;
    num2_next = e_num2; den2_next = e_den2; cnt_next = e_cnt; bpos_next = e_bpos;
    sat_next = e_sat; sat2_next = e_sat2;
    count_c = 1'b0; fin = 1'b0; fin_sec = 1'b0; fin_len = e_cnt;
    case (e_phase)
      PH_LEAD, PH_INT: begin
        if (ws && e_phase == PH_LEAD) begin
          count_c = 1'b1;
        end else if (dig) begin
          if (m10[64]) begin
            mant_next = '1; sat_next = 1'b1;
          end else begin
            mant_next = m10[63:0];
          end
          count_c = 1'b1; phase_next = PH_INT;
        end else if (ch == mftp_pkg::CH_POINT) begin
          count_c = 1'b1; phase_next = PH_DEC;
        end else if (ch == mftp_pkg::CH_SLASH) begin
          bpos_next = e_cnt; count_c = 1'b1; phase_next = PH_SL1;
        end else if (ws) begin
          count_c = 1'b1; phase_next = PH_MID;
        end else begin
          fin = 1'b1;
        end
      end
      PH_DEC: begin
        if (dig) begin
          if (e_dcnt < mftp_pkg::DEC_MAX && !m10[64]) begin
            mant_next = m10[63:0]; dcnt_next = e_dcnt + 1'b1;
          end
          count_c = 1'b1;
        end else if (ch == mftp_pkg::CH_SLASH) begin
          bpos_next = e_cnt; count_c = 1'b1; phase_next = PH_SL1;
        end else if (ws) begin
          count_c = 1'b1; phase_next = PH_MID;
        end else begin
          fin = 1'b1;
        end
      end
      PH_SL1: begin
        if (!dig) begin
          fin = 1'b1; fin_len = e_bpos;
        end else begin
          den1_next = {28'b0, d}; count_c = 1'b1; phase_next = PH_DEN1;
        end
      end
      PH_DEN1: begin
        if (dig) begin
          den1_next = a_den1[32] ? '1 : a_den1[31:0];
          if (a_den1[32]) sat_next = 1'b1;
          count_c = 1'b1;
        end else if (ws) begin
          count_c = 1'b1; phase_next = PH_MID;
        end else begin
          fin = 1'b1;
        end
      end
      PH_MID: begin
        if (ws) begin
          count_c = 1'b1;
        end else if (dig) begin
          bpos_next = e_cnt; num2_next = {28'b0, d}; den2_next = '0; sat2_next = 1'b0;
          count_c = 1'b1; phase_next = PH_NUM2;
        end else begin
          fin = 1'b1;
        end
      end
      PH_NUM2: begin
        if (dig) begin
          num2_next = a_num2[32] ? '1 : a_num2[31:0];
          if (a_num2[32]) sat2_next = 1'b1;
          count_c = 1'b1;
        end else if (ch == mftp_pkg::CH_SLASH) begin
          count_c = 1'b1; phase_next = PH_SL2;
        end else begin
          fin = 1'b1; fin_len = e_bpos;
        end
      end
      PH_SL2: begin
        if (!dig) begin
          fin = 1'b1; fin_len = e_bpos;
        end else begin
          den2_next = {28'b0, d}; count_c = 1'b1; phase_next = PH_DEN2;
        end
      end
      PH_DEN2: begin
        if (dig) begin
          den2_next = a_den2[32] ? '1 : a_den2[31:0];
          if (a_den2[32]) sat2_next = 1'b1;
          count_c = 1'b1;
        end else begin
          fin = 1'b1; fin_sec = 1'b1;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    if (count_c) begin
      if (e_cnt < CNT_W'(MAX_LENGTH)) cnt_next = e_cnt + 1'b1;
      else sat_next = 1'b1;
    end
    if (fin) phase_next = PH_IDLE;
  end

  assign push = accept && active && fin;
  always_comb begin
    job.mant        = e_mant;
    job.dcnt        = e_dcnt;
    job.den1        = e_den1;
    job.num2        = e_num2;
    job.den2        = e_den2;
    job.with_second = fin_sec;
    job.sat         = e_sat;
    job.sat2        = e_sat2;
    job.len         = mftp_pkg::LEN_W'(fin_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; mant <= '0; dcnt <= '0; den1 <= '0; num2 <= '0; den2 <= '0;
      cnt <= '0; bpos <= '0; sat <= 1'b0; sat2 <= 1'b0;
    end else if (accept && active) begin
      phase <= phase_next; mant <= mant_next; dcnt <= dcnt_next; den1 <= den1_next;
      num2 <= num2_next; den2 <= den2_next; cnt <= cnt_next; bpos <= bpos_next;
      sat <= sat_next; sat2 <= sat2_next;
    end
  end
endmodule

[hdl/mftp_queue.sv]
// Two-entry job queue between the parser and the evaluator.
`timescale 1ns / 1ps
module mftp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mftp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output mftp_pkg::job_t pop_job
);
  mftp_pkg::job_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign avail   = (fill != 2'd0);
  assign pop_job = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_job;
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !avail |-> !pop)
    else $error("queue read while empty");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill count out of range");
endmodule

[hdl/mftp_back.sv]
// Evaluator: builds the divisor, runs the bit-serial divisions and holds the result.
`timescale 1ns / 1ps
module mftp_back #(
  parameter int FRACTION_BITS = mftp_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_avail,
  input  mftp_pkg::job_t             q_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [63:0]                value,
  output logic [mftp_pkg::LEN_W-1:0] consumed_length,
  output logic                       divide_by_zero,
  output logic                       overflow
);
  localparam int NW     = 64 + FRACTION_BITS;
  localparam int STEP_W = $clog2(NW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_PREP, S_DIV, S_DEND, S_SEC, S_SUM, S_FIN
  } state_t;

  state_t         state;
  mftp_pkg::job_t job;
  logic [63:0]    pw, p0, p1, v1, q;
  logic [95:0]    dvs;
  logic [95:0]    rem;
  logic [96:0]    r2;
  logic [NW-1:0]  dvd;
  logic [STEP_W-1:0] steps;
  logic           qhi, second, dz, ov, qbit;
  logic [64:0]    sum;

  assign pop  = (state == S_IDLE) && q_avail && !out_valid;
  assign pw   = mftp_pkg::pow_ten(job.dcnt);
  assign r2   = {rem, dvd[NW-1]};
  assign qbit = (r2 >= {1'b0, dvs});
  assign sum  = {1'b0, v1} + {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; second <= 1'b0; dz <= 1'b0; ov <= 1'b0;
      qhi <= 1'b0; steps <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            job <= q_job; second <= 1'b0; dz <= 1'b0; ov <= q_job.sat; v1 <= '0;
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          p0 <= 64'(pw[31:0] * job.den1);
          state <= S_MUL1;
        end
        S_MUL1: begin
          p1 <= 64'(pw[63:32] * job.den1);
          state <= S_PREP;
        end
        S_PREP: begin
          if (job.den1 == '0) begin
            dz <= 1'b1; state <= S_SEC;
          end else begin
            dvs   <= {32'b0, p0} + {p1, 32'b0};
            dvd   <= {job.mant, {FRACTION_BITS{1'b0}}};
            rem   <= '0; q <= '0; qhi <= 1'b0;
            steps <= STEP_W'(NW);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem   <= qbit ? 96'(r2 - {1'b0, dvs}) : r2[95:0];
          dvd   <= dvd << 1;
          q     <= {q[62:0], qbit};
          qhi   <= qhi | q[63];
          steps <= steps - 1'b1;
          if (steps == STEP_W'(1)) state <= S_DEND;
        end
        S_DEND: begin
          if (qhi) begin
            q <= '1; ov <= 1'b1;
          end
          if (second) begin
            state <= S_SUM;
          end else begin
            v1    <= qhi ? '1 : q;
            state <= S_SEC;
          end
        end
        S_SEC: begin
          if (!job.with_second) begin
            state <= S_FIN;
          end else begin
            if (job.sat2) ov <= 1'b1;
            if (job.den2 == '0) begin
              dz <= 1'b1; state <= S_FIN;
            end else begin
              second <= 1'b1;
              dvs    <= {64'b0, job.den2};
              dvd    <= NW'({32'b0, job.num2, {FRACTION_BITS{1'b0}}});
              rem    <= '0; q <= '0; qhi <= 1'b0;
              steps  <= STEP_W'(NW);
              state  <= S_DIV;
            end
          end
        end
        S_SUM: begin
          if (sum[64]) begin
            v1 <= '1; ov <= 1'b1;
          end else begin
            v1 <= sum[63:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          value           <= dz ? '1 : v1;
          consumed_length <= job.len;
          divide_by_zero  <= dz;
          overflow        <= ov;
          out_valid       <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_dz_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> value == '1)
    else $error("division by zero without saturated value");
  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the finishing step");
  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> steps != '0)
    else $error("divider running with no steps left");
  a_pop_free: assert property (@(posedge clk) disable iff (rst) pop |-> !out_valid)
    else $error("job taken while result register is occupied");
endmodule
